[sv/spdf_pkg.sv]
// Shared types, constants and helper functions for the scrambled packet deframer.
package spdf_pkg;

	localparam int MaxPayload = 25;
	localparam int QueueDepth = 4;
	localparam int QueuePtrW  = $clog2(QueueDepth);

	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_INIT = 16'hB5D2;

	localparam logic [2:0] ADDR_MIN = 3'd3;
	localparam logic [2:0] ADDR_MAX = 3'd5;
	localparam logic [2:0] ADDR_RST = 3'd5;
	localparam logic [4:0] PAY_MAX  = 5'(MaxPayload);
	localparam logic [4:0] PAY_RST  = 5'd24;
	localparam logic [5:0] CRC_LEN  = 6'd2;

	localparam logic [0:0] REG_ADDRESS_BYTES = 1'b0;
	localparam logic [0:0] REG_PAYLOAD_BYTES = 1'b1;

	typedef enum logic [1:0] {
		SEC_ADDR    = 2'd0,
		SEC_PAYLOAD = 2'd1,
		SEC_CRC     = 2'd2
	} sect_t;

	// One completed raw byte with everything the back end needs to finish it.
	typedef struct packed {
		logic [7:0] raw;
		logic [4:0] idx;
		sect_t      sect;
		logic       last;
		logic [4:0] xi;
	} spdf_entry_t;

	localparam logic [7:0] SCRAMBLE_ROM [0:31] = '{
		8'he3, 8'hb1, 8'h4b, 8'hea, 8'h85, 8'hbc, 8'he5, 8'h66,
		8'h0d, 8'hae, 8'h8c, 8'h88, 8'h12, 8'h69, 8'hee, 8'h1f,
		8'hc7, 8'h62, 8'h97, 8'hd5, 8'h0b, 8'h79, 8'hca, 8'hcc,
		8'h1b, 8'h5d, 8'h19, 8'h10, 8'h24, 8'hd3, 8'hdc, 8'h3f
	};

	localparam int XorLen = 28;
	localparam logic [15:0] XOROUT_ROM [0:XorLen-1] = '{
		16'h0000, 16'h3448, 16'h9BA7, 16'h8BBB, 16'h85E1, 16'h3E8C,
		16'h451E, 16'h18E6, 16'h6B24, 16'hE7AB, 16'h3828, 16'h814B,
		16'hD461, 16'hF494, 16'h2503, 16'h691D, 16'hFE8B, 16'h9BA7,
		16'h8B17, 16'h2920, 16'h8B5F, 16'h61B1, 16'hD391, 16'h7401,
		16'h2138, 16'h129F, 16'hB3A0, 16'h2988
	};

	function automatic logic [15:0] xorout_lookup(input logic [4:0] xi);
		logic [15:0] r;
		r = 16'h0000;
		if (xi < 5'(XorLen)) begin
			r = XOROUT_ROM[xi];
		end
		return r;
	endfunction

	// CRC16-CCITT, MSB first, one byte.
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

	function automatic logic [7:0] rev8(input logic [7:0] b);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[i] = b[7-i];
		end
		return r;
	endfunction

endpackage

[sv/spdf_front.sv]
// Front end: configuration registers, bit packing, packet framing and byte classification.
module spdf_front
	import spdf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [0:0]  wr_index,
	input  logic [4:0]  wr_data,
	input  logic        bit_valid,
	output logic        bit_ready,
	input  logic        data_bit,
	input  logic        sync_flag,
	input  logic        queue_full,
	output logic        push,
	output spdf_entry_t push_entry
);

	logic [2:0] addr_bytes_q;
	logic [4:0] pay_bytes_q;
	logic [7:0] shift_q;
	logic [2:0] bitc_q;
	logic [4:0] bytec_q;
	logic       in_packet_q;

	logic       accept;
	logic       in_pkt;
	logic [7:0] shift_base;
	logic [2:0] bitc_base;
	logic [4:0] idx_base;
	logic [7:0] new_shift;
	logic       byte_done;
	logic [2:0] alen;
	logic [4:0] plen;
	logic [5:0] addr_pay;
	logic [5:0] total;
	logic [5:0] idx_next;
	logic       last;
	sect_t      sect;

	assign bit_ready = !queue_full;
	assign accept    = bit_valid && bit_ready;

	always_comb begin
		in_pkt     = sync_flag || in_packet_q;
		shift_base = sync_flag ? 8'h00 : shift_q;
		bitc_base  = sync_flag ? 3'd0 : bitc_q;
		idx_base   = sync_flag ? 5'd0 : bytec_q;
		new_shift  = shift_base | ({7'd0, data_bit} << (3'd7 - bitc_base));
		byte_done  = in_pkt && (bitc_base == 3'd7);

		if (addr_bytes_q < ADDR_MIN) begin
			alen = ADDR_MIN;
		end else if (addr_bytes_q > ADDR_MAX) begin
			alen = ADDR_MAX;
		end else begin
			alen = addr_bytes_q;
		end
		plen = (pay_bytes_q > PAY_MAX) ? PAY_MAX : pay_bytes_q;

		addr_pay = {3'd0, alen} + {1'b0, plen};
		total    = addr_pay + CRC_LEN;
		idx_next = {1'b0, idx_base} + 6'd1;
		last     = idx_next >= total;

		if ({1'b0, idx_base} < {3'd0, alen}) begin
			sect = SEC_ADDR;
		end else if ({1'b0, idx_base} < addr_pay) begin
			sect = SEC_PAYLOAD;
		end else begin
			sect = SEC_CRC;
		end

		push            = accept && byte_done;
		push_entry.raw  = new_shift;
		push_entry.idx  = idx_base;
		push_entry.sect = sect;
		push_entry.last = last;
		push_entry.xi   = {2'd0, alen} - {2'd0, ADDR_MIN} + plen;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_bytes_q <= ADDR_RST;
			pay_bytes_q  <= PAY_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_ADDRESS_BYTES: addr_bytes_q <= wr_data[2:0];
				REG_PAYLOAD_BYTES: pay_bytes_q  <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q     <= 8'h00;
			bitc_q      <= 3'd0;
			bytec_q     <= 5'd0;
			in_packet_q <= 1'b0;
		end else if (accept && in_pkt) begin
			shift_q     <= byte_done ? 8'h00 : new_shift;
			bitc_q      <= bitc_base + 3'd1;
			bytec_q     <= byte_done ? idx_next[4:0] : idx_base;
			in_packet_q <= !(byte_done && last);
		end
	end

endmodule

[sv/spdf_queue.sv]
// Short queue of classified bytes between the front and back ends.
module spdf_queue
	import spdf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  spdf_entry_t push_entry,
	output logic        full,
	input  logic        pop,
	output spdf_entry_t pop_entry,
	output logic        empty
);

	spdf_entry_t            entries_q [0:QueueDepth-1];
	logic [QueuePtrW-1:0]   wr_ptr_q;
	logic [QueuePtrW-1:0]   rd_ptr_q;
	logic [QueuePtrW:0]     count_q;

	assign full      = (count_q == (QueuePtrW+1)'(QueueDepth));
	assign empty     = (count_q == '0);
	assign pop_entry = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QueuePtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QueuePtrW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QueuePtrW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QueuePtrW+1)'(1);
			end
		end
	end

endmodule

[sv/spdf_back.sv]
// Back end: CRC accumulation, descrambling and the output register.
module spdf_back
	import spdf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        queue_empty,
	input  spdf_entry_t pop_entry,
	output logic        pop,
	output logic        byte_valid,
	input  logic        byte_ready,
	output logic [7:0]  byte_value,
	output logic [1:0]  section,
	output logic [4:0]  byte_index,
	output logic        packet_end,
	output logic [15:0] computed_crc
);

	logic        byte_valid_q;
	logic [7:0]  byte_value_q;
	logic [1:0]  section_q;
	logic [4:0]  byte_index_q;
	logic        packet_end_q;
	logic [15:0] computed_crc_q;
	logic [15:0] crc_q;

	logic [15:0] crc_in;
	logic [15:0] crc_upd;
	logic [15:0] crc_fin;
	logic [7:0]  scr;
	logic [7:0]  value;

	assign pop = !queue_empty && (!byte_valid_q || byte_ready);

	always_comb begin
		// The first byte of a packet starts from the seed value.
		crc_in = (pop_entry.idx == 5'd0) ? CRC_INIT : crc_q;
		scr    = SCRAMBLE_ROM[pop_entry.idx];
		unique case (pop_entry.sect)
			SEC_ADDR: begin
				crc_upd = crc_byte(crc_in, pop_entry.raw);
				value   = pop_entry.raw ^ scr;
			end
			SEC_PAYLOAD: begin
				crc_upd = crc_byte(crc_in, pop_entry.raw);
				value   = rev8(pop_entry.raw ^ scr);
			end
			default: begin
				crc_upd = crc_in;
				value   = pop_entry.raw;
			end
		endcase
		crc_fin = pop_entry.last ? (crc_upd ^ xorout_lookup(pop_entry.xi)) : crc_upd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_q <= 1'b0;
			crc_q        <= CRC_INIT;
		end else if (pop) begin
			byte_valid_q <= 1'b1;
			crc_q        <= crc_fin;
		end else if (byte_ready) begin
			byte_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			byte_value_q   <= value;
			section_q      <= pop_entry.sect;
			byte_index_q   <= pop_entry.idx;
			packet_end_q   <= pop_entry.last;
			computed_crc_q <= pop_entry.last ? crc_fin : 16'h0000;
		end
	end

	assign byte_valid   = byte_valid_q;
	assign byte_value   = byte_value_q;
	assign section      = section_q;
	assign byte_index   = byte_index_q;
	assign packet_end   = packet_end_q;
	assign computed_crc = computed_crc_q;

endmodule

[sv/scrambled_packet_deframer_core.sv]
// A completed byte passes through the byte queue and then the output register.
// Throughput: one bit per cycle while the byte queue is not full; one result per eight bits at most.
// bit_ready drops only when the four-entry byte queue is full under output backpressure.
// Reset (arst_n low, asynchronous): no packet open, counters cleared, CRC seed loaded,
// address_bytes 5, payload_bytes 24, queue and output register empty.
module scrambled_packet_deframer_core
	import spdf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [0:0]  wr_index,
	input  logic [4:0]  wr_data,
	input  logic        bit_valid,
	output logic        bit_ready,
	input  logic        data_bit,
	input  logic        sync_flag,
	output logic        byte_valid,
	input  logic        byte_ready,
	output logic [7:0]  byte_value,
	output logic [1:0]  section,
	output logic [4:0]  byte_index,
	output logic        packet_end,
	output logic [15:0] computed_crc
);

	logic        push;
	logic        pop;
	logic        queue_full;
	logic        queue_empty;
	spdf_entry_t push_entry;
	spdf_entry_t pop_entry;

	spdf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.bit_valid  (bit_valid),
		.bit_ready  (bit_ready),
		.data_bit   (data_bit),
		.sync_flag  (sync_flag),
		.queue_full (queue_full),
		.push       (push),
		.push_entry (push_entry)
	);

	spdf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (queue_full),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.empty      (queue_empty)
	);

	spdf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.queue_empty  (queue_empty),
		.pop_entry    (pop_entry),
		.pop          (pop),
		.byte_valid   (byte_valid),
		.byte_ready   (byte_ready),
		.byte_value   (byte_value),
		.section      (section),
		.byte_index   (byte_index),
		.packet_end   (packet_end),
		.computed_crc (computed_crc)
	);

endmodule

[sv/spdf_checker.sv]
// Port-level checker for the deframer and its bind to the top level.
module spdf_checker
	import spdf_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        byte_valid,
	input logic        byte_ready,
	input logic [7:0]  byte_value,
	input logic [1:0]  section,
	input logic [4:0]  byte_index,
	input logic        packet_end,
	input logic [15:0] computed_crc
);

	// A stalled result transaction keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && !byte_ready |=> byte_valid && $stable(byte_value)
			&& $stable(byte_index) && $stable(packet_end) && $stable(computed_crc))
		else $error("result changed while stalled");

	// The CRC field is only populated on the closing byte.
	a_crc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && !packet_end |-> computed_crc == 16'h0000)
		else $error("computed_crc nonzero on a non-final byte");

	// A packet always ends on one of the received CRC bytes.
	a_end_in_crc: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && packet_end |-> section == SEC_CRC)
		else $error("packet ended outside the CRC section");

	// The first three bytes of every packet are address bytes.
	a_addr_head: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && byte_index < 5'd3 |-> section == SEC_ADDR)
		else $error("leading byte not in address section");

endmodule

bind scrambled_packet_deframer_core spdf_checker u_spdf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.byte_valid   (byte_valid),
	.byte_ready   (byte_ready),
	.byte_value   (byte_value),
	.section      (section),
	.byte_index   (byte_index),
	.packet_end   (packet_end),
	.computed_crc (computed_crc)
);

[verif/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the scrambled packet deframer core.
module tb_top;
	import spdf_pkg::*;

	typedef struct packed {
		logic [7:0]  value;
		sect_t       sect;
		logic [4:0]  idx;
		logic        last;
		logic [15:0] crc;
	} byte_result_t;

	typedef enum logic {ROW_CFG, ROW_BITS} row_kind_t;

	typedef struct packed {
		row_kind_t    kind;
		logic [2:0]   addr_len;
		logic [4:0]   pay_len;
		logic         sync;
		logic [3:0]   nbits;
		logic [7:0]   pattern;
		logic         typed;
		byte_result_t want;
	} stim_row_t;

	localparam byte_result_t NO_RESULT = '0;

	localparam logic [7:0] DESCRAMBLE_KEY [0:31] = '{
		8'he3, 8'hb1, 8'h4b, 8'hea, 8'h85, 8'hbc, 8'he5, 8'h66,
		8'h0d, 8'hae, 8'h8c, 8'h88, 8'h12, 8'h69, 8'hee, 8'h1f,
		8'hc7, 8'h62, 8'h97, 8'hd5, 8'h0b, 8'h79, 8'hca, 8'hcc,
		8'h1b, 8'h5d, 8'h19, 8'h10, 8'h24, 8'hd3, 8'hdc, 8'h3f
	};

	localparam logic [15:0] CRC_XOROUT_KEY [0:27] = '{
		16'h0000, 16'h3448, 16'h9BA7, 16'h8BBB, 16'h85E1, 16'h3E8C,
		16'h451E, 16'h18E6, 16'h6B24, 16'hE7AB, 16'h3828, 16'h814B,
		16'hD461, 16'hF494, 16'h2503, 16'h691D, 16'hFE8B, 16'h9BA7,
		16'h8B17, 16'h2920, 16'h8B5F, 16'h61B1, 16'hD391, 16'h7401,
		16'h2138, 16'h129F, 16'hB3A0, 16'h2988
	};

	// Short packets with the lengths clamped from both sides, a resync in the middle of
	// a byte, and two length changes while a packet is open (the second one ends it).
	localparam stim_row_t DIRECTED_ROWS [28] = '{
		'{ROW_BITS, 3'd0, 5'd0,  1'b0, 4'd5, 8'hFF, 1'b0, NO_RESULT},
		'{ROW_CFG,  3'd0, 5'd0,  1'b0, 4'd0, 8'h00, 1'b0, NO_RESULT},
		'{ROW_BITS, 3'd0, 5'd0,  1'b1, 4'd8, 8'h00, 1'b1,
			'{8'he3, SEC_ADDR, 5'd0, 1'b0, 16'h0000}},
		'{ROW_BITS, 3'd0, 5'd0,  1'b0, 4'd8, 8'hFF, 1'b1,
			'{8'h4e, SEC_ADDR, 5'd1, 1'b0, 16'h0000}},
		'{ROW_BITS, 3'd0, 5'd0,  1'b0, 4'd8, 8'h4b, 1'b1,
			'{8'h00, SEC_ADDR, 5'd2, 1'b0, 16'h0000}},
		'{ROW_BITS, 3'd0, 5'd0,  1'b0, 4'd8, 8'h5A, 1'b1,
			'{8'h5A, SEC_CRC, 5'd3, 1'b0, 16'h0000}},
		'{ROW_BITS, 3'd0, 5'd0,  1'b0, 4'd8, 8'hA5, 1'b0, NO_RESULT},
		'{ROW_BITS, 3'd0, 5'd0,  1'b0, 4'd3, 8'hE0, 1'b0, NO_RESULT},
		'{ROW_BITS, 3'd0, 5'd0,  1'b1, 4'd3, 8'hA0, 1'b0, NO_RESULT},
		'{ROW_BITS, 3'd0, 5'd0,  1'b1, 4'd8, 8'hFF, 1'b1,
			'{8'h1c, SEC_ADDR, 5'd0, 1'b0, 16'h0000}},
		'{ROW_BITS, 3'd0, 5'd0,  1'b0, 4'd8, 8'h80, 1'b0, NO_RESULT},
		'{ROW_CFG,  3'd7, 5'd1,  1'b0, 4'd0, 8'h00, 1'b0, NO_RESULT},
		'{ROW_BITS, 3'd0, 5'd0,  1'b0, 4'd8, 8'h01, 1'b0, NO_RESULT},
		'{ROW_BITS, 3'd0, 5'd0,  1'b0, 4'd8, 8'h00, 1'b1,
			'{8'hea, SEC_ADDR, 5'd3, 1'b0, 16'h0000}},
		'{ROW_BITS, 3'd0, 5'd0,  1'b0, 4'd8, 8'h00, 1'b1,
			'{8'h85, SEC_ADDR, 5'd4, 1'b0, 16'h0000}},
		'{ROW_BITS, 3'd0, 5'd0,  1'b0, 4'd8, 8'h00, 1'b1,
			'{8'h3d, SEC_PAYLOAD, 5'd5, 1'b0, 16'h0000}},
		'{ROW_BITS, 3'd0, 5'd0,  1'b0, 4'd8, 8'hC3, 1'b1,
			'{8'hC3, SEC_CRC, 5'd6, 1'b0, 16'h0000}},
		'{ROW_BITS, 3'd0, 5'd0,  1'b0, 4'd8, 8'h3C, 1'b0, NO_RESULT},
		'{ROW_CFG,  3'd5, 5'd31, 1'b0, 4'd0, 8'h00, 1'b0, NO_RESULT},
		'{ROW_BITS, 3'd0, 5'd0,  1'b1, 4'd8, 8'hFF, 1'b0, NO_RESULT},
		'{ROW_BITS, 3'd0, 5'd0,  1'b0, 4'd8, 8'hFF, 1'b0, NO_RESULT},
		'{ROW_BITS, 3'd0, 5'd0,  1'b0, 4'd8, 8'hFF, 1'b0, NO_RESULT},
		'{ROW_BITS, 3'd0, 5'd0,  1'b0, 4'd8, 8'hFF, 1'b0, NO_RESULT},
		'{ROW_BITS, 3'd0, 5'd0,  1'b0, 4'd8, 8'hFF, 1'b0, NO_RESULT},
		'{ROW_BITS, 3'd0, 5'd0,  1'b0, 4'd8, 8'hFF, 1'b1,
			'{8'hc2, SEC_PAYLOAD, 5'd5, 1'b0, 16'h0000}},
		'{ROW_CFG,  3'd4, 5'd0,  1'b0, 4'd0, 8'h00, 1'b0, NO_RESULT},
		'{ROW_BITS, 3'd0, 5'd0,  1'b0, 4'd8, 8'hFF, 1'b0, NO_RESULT},
		'{ROW_BITS, 3'd0, 5'd0,  1'b0, 4'd8, 8'h55, 1'b0, NO_RESULT}
	};

	logic        clk;
	logic        arst_n = 1'b0;
	logic        wr_en = 1'b0;
	logic [0:0]  wr_index = REG_ADDRESS_BYTES;
	logic [4:0]  wr_data = '0;
	logic        bit_valid = 1'b0;
	logic        bit_ready;
	logic        data_bit = 1'b0;
	logic        sync_flag = 1'b0;
	logic        byte_valid;
	logic        byte_ready = 1'b0;
	logic [7:0]  byte_value;
	logic [1:0]  section;
	logic [4:0]  byte_index;
	logic        packet_end;
	logic [15:0] computed_crc;

	// Predictor copy of the deframer state and its two length registers.
	logic [7:0]  pr_shift;
	logic [2:0]  pr_bits;
	logic [4:0]  pr_count;
	logic [15:0] pr_crc;
	logic        pr_open;
	logic [2:0]  cur_addr_len;
	logic [4:0]  cur_pay_len;

	byte_result_t byte_results_due[$];
	bit calm = 1'b0;
	int n_bits_in = 0;
	int n_bytes_out = 0;
	int n_packets_closed = 0;
	int n_settings = 0;
	int mismatches = 0;

	scrambled_packet_deframer_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.bit_valid    (bit_valid),
		.bit_ready    (bit_ready),
		.data_bit     (data_bit),
		.sync_flag    (sync_flag),
		.byte_valid   (byte_valid),
		.byte_ready   (byte_ready),
		.byte_value   (byte_value),
		.section      (section),
		.byte_index   (byte_index),
		.packet_end   (packet_end),
		.computed_crc (computed_crc)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			r = r[15] ? ({r[14:0], 1'b0} ^ 16'h1021) : {r[14:0], 1'b0};
		end
		return r;
	endfunction

	function automatic logic [7:0] mirror8(input logic [7:0] b);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[i] = b[7-i];
		end
		return r;
	endfunction

	function automatic int clamped_addr_len();
		return (cur_addr_len < 3) ? 3 : ((cur_addr_len > 5) ? 5 : int'(cur_addr_len));
	endfunction

	function automatic int clamped_pay_len();
		return (cur_pay_len > 25) ? 25 : int'(cur_pay_len);
	endfunction

	// Advances the predictor by one received bit; produced is set when a byte completes.
	task automatic deframe_bit(input logic d, input logic s, output bit produced,
			output byte_result_t res);
		int alen;
		int plen;
		logic [4:0] idx;
		produced = 1'b0;
		res = NO_RESULT;
		if (s) begin
			pr_shift = '0;
			pr_bits = '0;
			pr_count = '0;
			pr_crc = 16'hB5D2;
			pr_open = 1'b1;
		end
		if (!pr_open) begin
			return;
		end
		if (d) begin
			pr_shift[3'd7 - pr_bits] = 1'b1;
		end
		pr_bits = pr_bits + 3'd1;
		if (pr_bits != 3'd0) begin
			return;
		end
		alen = clamped_addr_len();
		plen = clamped_pay_len();
		idx = pr_count;
		res.idx = idx;
		if (idx < alen) begin
			pr_crc = crc16_step(pr_crc, pr_shift);
			res.value = pr_shift ^ DESCRAMBLE_KEY[idx];
			res.sect = SEC_ADDR;
		end else if (idx < alen + plen) begin
			pr_crc = crc16_step(pr_crc, pr_shift);
			res.value = mirror8(pr_shift) ^ mirror8(DESCRAMBLE_KEY[idx]);
			res.sect = SEC_PAYLOAD;
		end else begin
			res.value = pr_shift;
			res.sect = SEC_CRC;
		end
		pr_shift = '0;
		pr_count = idx + 5'd1;
		res.last = (int'(idx) + 1 >= alen + plen + 2);
		res.crc = '0;
		if (res.last) begin
			pr_open = 1'b0;
			pr_crc = pr_crc ^ CRC_XOROUT_KEY[alen - 3 + plen];
			res.crc = pr_crc;
		end
		produced = 1'b1;
	endtask

	task automatic send_bit(input logic d, input logic s, input bit use_typed,
			input byte_result_t typed_res);
		bit produced;
		bit counted;
		byte_result_t res;
		if (!calm) begin
			while ($urandom_range(0, 99) < 32) begin
				bit_valid <= 1'b0;
				@(posedge clk);
			end
		end
		bit_valid <= 1'b1;
		data_bit <= d;
		sync_flag <= s;
		do @(posedge clk); while (!bit_ready);
		counted = s || pr_open;
		deframe_bit(d, s, produced, res);
		if (counted) begin
			n_bits_in++;
		end
		if (produced) begin
			byte_results_due.push_back(use_typed ? typed_res : res);
		end
	endtask

	// Holds the sender back until every expected byte is out and the pipeline is quiet.
	task automatic drain();
		bit_valid <= 1'b0;
		while (byte_results_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (6) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [2:0] addr_len, input logic [4:0] pay_len);
		wr_en <= 1'b1;
		wr_index <= REG_ADDRESS_BYTES;
		wr_data <= {2'b00, addr_len};
		@(posedge clk);
		wr_index <= REG_PAYLOAD_BYTES;
		wr_data <= pay_len;
		@(posedge clk);
		wr_en <= 1'b0;
		cur_addr_len = addr_len;
		cur_pay_len = pay_len;
		n_settings++;
	endtask

	// Output side: random backpressure, and every transaction checked in order.
	initial begin
		byte_result_t want;
		forever begin
			@(posedge clk);
			if (arst_n && byte_valid && byte_ready) begin
				n_bytes_out++;
				if (packet_end) begin
					n_packets_closed++;
				end
				if (byte_results_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("ERROR: unexpected byte %02h section %0d index %0d",
							byte_value, section, byte_index);
					end
				end else begin
					want = byte_results_due.pop_front();
					if (byte_value !== want.value || section !== want.sect ||
							byte_index !== want.idx || packet_end !== want.last ||
							computed_crc !== want.crc) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("ERROR: expected byte %02h sect %0d idx %0d end %0d crc %04h",
								want.value, want.sect, want.idx, want.last, want.crc);
							$display("       actual   byte %02h sect %0d idx %0d end %0d crc %04h",
								byte_value, section, byte_index, packet_end, computed_crc);
						end
					end
				end
			end
			byte_ready <= calm || ($urandom_range(0, 99) >= 32);
		end
	end

	initial begin
		int phase;
		int npk;
		int kind;
		int nbits_pkt;
		int resync_at;
		bit left_open;
		logic [2:0] a;
		logic [4:0] p;

		pr_shift = '0;
		pr_bits = '0;
		pr_count = '0;
		pr_crc = 16'hB5D2;
		pr_open = 1'b0;
		cur_addr_len = 3'd5;
		cur_pay_len = 5'd24;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_ROWS[i]) begin
			if (DIRECTED_ROWS[i].kind == ROW_CFG) begin
				drain();
				cfg_write(DIRECTED_ROWS[i].addr_len, DIRECTED_ROWS[i].pay_len);
			end else begin
				for (int b = 0; b < DIRECTED_ROWS[i].nbits; b++) begin
					send_bit(DIRECTED_ROWS[i].pattern[7-b], DIRECTED_ROWS[i].sync && b == 0,
						DIRECTED_ROWS[i].typed && b == DIRECTED_ROWS[i].nbits - 1,
						DIRECTED_ROWS[i].want);
				end
			end
		end

		// Random phases: mostly whole packets with random content, some noise between
		// packets, some cut short or resynced, and sometimes a packet left open across
		// a length change.
		phase = 0;
		left_open = 1'b0;
		while (n_bits_in < 400 || n_bytes_out < 60) begin
			drain();
			if (phase == 0) begin
				a = 3'd7;
				p = 5'd31;
				calm = 1'b1;
			end else if (phase == 1) begin
				a = 3'($urandom_range(0, 3));
				p = 5'd0;
				calm = 1'b0;
			end else begin
				a = 3'($urandom_range(0, 7));
				p = 5'(($urandom_range(0, 7) == 0) ? $urandom_range(25, 31)
					: $urandom_range(0, 4));
			end
			cfg_write(a, p);
			if (left_open) begin
				repeat ($urandom_range(1, 40)) send_bit(1'($urandom_range(0, 1)), 1'b0, 1'b0,
					NO_RESULT);
			end
			left_open = 1'b0;
			npk = (phase == 0) ? 1 : $urandom_range(1, 3);
			for (int k = 0; k < npk; k++) begin
				if ($urandom_range(0, 3) == 0) begin
					repeat ($urandom_range(1, 12)) begin
						send_bit(1'($urandom_range(0, 1)), 1'b0, 1'b0, NO_RESULT);
					end
				end
				nbits_pkt = 8 * (clamped_addr_len() + clamped_pay_len() + 2);
				kind = (phase == 0) ? 0 : $urandom_range(0, 9);
				resync_at = (kind == 7) ? $urandom_range(1, nbits_pkt - 1) : -1;
				if (kind >= 8 || (phase > 0 && k == npk - 1 && $urandom_range(0, 3) == 0)) begin
					nbits_pkt = $urandom_range(1, nbits_pkt - 1);
					left_open = (k == npk - 1);
				end
				for (int b = 0; b < nbits_pkt; b++) begin
					send_bit(1'($urandom_range(0, 1)), b == 0 || b == resync_at, 1'b0,
						NO_RESULT);
				end
			end
			phase++;
		end

		drain();
		repeat (20) @(posedge clk);
		$display("Covered %0d packet bits over %0d length settings, with noise, resyncs",
			n_bits_in, n_settings);
		$display("and open-packet length changes; %0d bytes in %0d closed packets checked.",
			n_bytes_out, n_packets_closed);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
